// ===== rtl/core/axis_limit_guard_with_slewup_unit_assert.svh =====
// assertion macros shared by the rtl
`ifndef AXIS_LIMIT_GUARD_WITH_SLEWUP_UNIT_ASSERT_SVH
`define AXIS_LIMIT_GUARD_WITH_SLEWUP_UNIT_ASSERT_SVH

`ifndef SYNTH

// clocked check, off while reset is held
`define ALG_ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// clocked check that also holds during reset
`define ALG_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`else

`define ALG_ASSERT_CLK(lbl, clk, rst_n, prop)
`define ALG_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ===== rtl/core/alg_pkg.sv =====
`default_nettype none

package alg_pkg;

    localparam int ANGLE_BITS_DEF = 32;
    localparam int TOL_BITS       = 31;
    localparam int CFG_IDX_BITS   = 3;

    localparam logic signed [63:0] ELEV_UPPER_RST = 64'sd105414357;
    localparam logic signed [63:0] ELEV_LOWER_RST = 64'sd0;
    localparam logic signed [63:0] AZIM_CW_RST    = 64'sd316243070;
    localparam logic signed [63:0] AZIM_CCW_RST   = -64'sd316243070;
    localparam logic [TOL_BITS-1:0] HELD_TOL_RST  = 31'd1171270;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_ELEV_UPPER = 3'd0,
        REG_ELEV_LOWER = 3'd1,
        REG_AZIM_CW    = 3'd2,
        REG_AZIM_CCW   = 3'd3,
        REG_HELD_TOL   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic up;
        logic dn;
        logic cw;
        logic cc;
    } t_limit_flags;

endpackage

`default_nettype wire

// ===== rtl/core/alg_cfg_regs.sv =====
`default_nettype none

module alg_cfg_regs
    import alg_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF,
    parameter int CFG_W      = ANGLE_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_wr_en,
    input  wire [CFG_IDX_BITS-1:0]       i_cfg_addr,
    input  wire [CFG_W-1:0]              i_cfg_wdata,
    output logic signed [ANGLE_BITS-1:0] o_elev_upper,
    output logic signed [ANGLE_BITS-1:0] o_elev_lower,
    output logic signed [ANGLE_BITS-1:0] o_azim_cw,
    output logic signed [ANGLE_BITS-1:0] o_azim_ccw,
    output logic [TOL_BITS-1:0]          o_held_tol
);

    logic signed [ANGLE_BITS-1:0] r_elev_upper;
    logic signed [ANGLE_BITS-1:0] r_elev_lower;
    logic signed [ANGLE_BITS-1:0] r_azim_cw;
    logic signed [ANGLE_BITS-1:0] r_azim_ccw;
    logic [TOL_BITS-1:0]          r_held_tol;
    logic [ANGLE_BITS-1:0]        wr_angle;

    assign wr_angle = i_cfg_wdata[ANGLE_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elev_upper <= ELEV_UPPER_RST[ANGLE_BITS-1:0];
            r_elev_lower <= ELEV_LOWER_RST[ANGLE_BITS-1:0];
            r_azim_cw    <= AZIM_CW_RST[ANGLE_BITS-1:0];
            r_azim_ccw   <= AZIM_CCW_RST[ANGLE_BITS-1:0];
            r_held_tol   <= HELD_TOL_RST;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                REG_ELEV_UPPER: r_elev_upper <= wr_angle;
                REG_ELEV_LOWER: r_elev_lower <= wr_angle;
                REG_AZIM_CW:    r_azim_cw    <= wr_angle;
                REG_AZIM_CCW:   r_azim_ccw   <= wr_angle;
                REG_HELD_TOL:   r_held_tol   <= i_cfg_wdata[TOL_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_elev_upper = r_elev_upper;
    assign o_elev_lower = r_elev_lower;
    assign o_azim_cw    = r_azim_cw;
    assign o_azim_ccw   = r_azim_ccw;
    assign o_held_tol   = r_held_tol;

endmodule

`default_nettype wire

// ===== rtl/core/alg_clamp.sv =====
`default_nettype none

module alg_clamp
    import alg_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  wire signed [ANGLE_BITS-1:0]  i_elev_upper,
    input  wire signed [ANGLE_BITS-1:0]  i_elev_lower,
    input  wire signed [ANGLE_BITS-1:0]  i_azim_cw,
    input  wire signed [ANGLE_BITS-1:0]  i_azim_ccw,
    input  wire signed [ANGLE_BITS-1:0]  i_scope_azim,
    input  wire signed [ANGLE_BITS-1:0]  i_scope_elev,
    input  wire signed [ANGLE_BITS-1:0]  i_goal_azim,
    input  wire signed [ANGLE_BITS-1:0]  i_goal_elev,
    output logic signed [ANGLE_BITS-1:0] o_goal_azim,
    output logic signed [ANGLE_BITS-1:0] o_goal_elev,
    output logic                         o_clamped,
    output t_limit_flags                 o_flags
);

    logic signed [ANGLE_BITS-1:0] elev_hi;
    logic signed [ANGLE_BITS-1:0] azim_hi;
    logic elev_hit_hi, elev_hit_lo, azim_hit_hi, azim_hit_lo;

    always_comb begin
        o_flags.up = i_scope_elev > i_elev_upper;
        o_flags.dn = i_scope_elev < i_elev_lower;
        o_flags.cw = i_scope_azim > i_azim_cw;
        o_flags.cc = i_scope_azim < i_azim_ccw;
    end

    // upper bound first, lower bound wins when the limits cross
    assign elev_hit_hi = i_goal_elev > i_elev_upper;
    assign elev_hi     = elev_hit_hi ? i_elev_upper : i_goal_elev;
    assign elev_hit_lo = elev_hi < i_elev_lower;
    assign o_goal_elev = elev_hit_lo ? i_elev_lower : elev_hi;

    assign azim_hit_hi = i_goal_azim > i_azim_cw;
    assign azim_hi     = azim_hit_hi ? i_azim_cw : i_goal_azim;
    assign azim_hit_lo = azim_hi < i_azim_ccw;
    assign o_goal_azim = azim_hit_lo ? i_azim_ccw : azim_hi;

    assign o_clamped = elev_hit_hi | elev_hit_lo | azim_hit_hi | azim_hit_lo;

endmodule

`default_nettype wire

// ===== rtl/core/alg_slewup.sv =====
`default_nettype none

module alg_slewup
    import alg_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_advance,
    input  wire                          i_below_lower,
    input  wire signed [ANGLE_BITS-1:0]  i_scope_azim,
    input  wire [TOL_BITS-1:0]           i_held_tol,
    output logic signed [ANGLE_BITS-1:0] o_held_azim,
    output logic                         o_slewing
);

    localparam int DIFF_W = ANGLE_BITS + 1;
    localparam int CMP_W  = (DIFF_W > TOL_BITS) ? DIFF_W : TOL_BITS;

    logic                         r_slewing_up;
    logic signed [ANGLE_BITS-1:0] r_held_azim;
    logic signed [ANGLE_BITS-1:0] n_held_azim;
    logic [DIFF_W-1:0]            diff;
    logic [DIFF_W-1:0]            abs_diff;
    logic                         take_new;

    assign diff = {i_scope_azim[ANGLE_BITS-1], i_scope_azim}
                - {r_held_azim[ANGLE_BITS-1], r_held_azim};
    assign abs_diff = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;

    assign take_new    = !r_slewing_up || (CMP_W'(abs_diff) > CMP_W'(i_held_tol));
    assign n_held_azim = take_new ? i_scope_azim : r_held_azim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slewing_up <= 1'b0;
            r_held_azim  <= '0;
        end else if (i_advance) begin
            r_slewing_up <= i_below_lower;
            if (i_below_lower) begin
                r_held_azim <= n_held_azim;
            end
        end
    end

    assign o_held_azim = n_held_azim;
    assign o_slewing   = r_slewing_up;

endmodule

`default_nettype wire

// ===== rtl/core/axis_limit_guard_with_slewup_unit.sv =====
// primary-limits guard for an azimuth / elevation mount
// slave channel: one item = telescope azimuth, telescope elevation, goal
// azimuth, goal elevation; master channel: one item per input item with the
// clamped goal, goal_changed, scope_inside and the four limit flags
// config: i_cfg_wr_en / i_cfg_addr / i_cfg_wdata write one limit register
// per cycle; the user must write only while no item is in flight (not enforced)
// path: an accepted item goes into the input register, then into the result
// register, whose valid flag drives tvalid on the master side
// throughput: one item per cycle while not stalled; the slew-up azimuth hold
// is updated as an item moves from the input register to the result register
// stall: a stalled result stays in the result register while the input
// register can still take one more item; s_axis_tready then drops until the
// receiver takes the result
// reset: synchronous active low, clears both valid flags and the slew-up
// state and loads the default limits
`default_nettype none

module axis_limit_guard_with_slewup_unit
    import alg_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF,
    parameter int CFG_W      = (ANGLE_BITS > TOL_BITS) ? ANGLE_BITS : TOL_BITS,
    parameter int IN_W       = ((4 * ANGLE_BITS + 7) / 8) * 8,
    parameter int OUT_W      = ((2 * ANGLE_BITS + 6 + 7) / 8) * 8
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_wr_en,
    input  wire [CFG_IDX_BITS-1:0] i_cfg_addr,
    input  wire [CFG_W-1:0]        i_cfg_wdata,
    input  wire                    s_axis_tvalid,
    output logic                   s_axis_tready,
    // scope_azim, scope_elev, goal_azim, goal_elev, zero pad
    input  wire [IN_W-1:0]         s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  wire                    m_axis_tready,
    // new_goal_azim, new_goal_elev, goal_changed, scope_inside,
    // over_counter_limit, over_clockwise_limit, under_lower_limit,
    // over_upper_limit, zero pad
    output logic [OUT_W-1:0]       m_axis_tdata
);

    localparam int AB = ANGLE_BITS;

    logic signed [AB-1:0] elev_upper, elev_lower, azim_cw, azim_ccw;
    logic [TOL_BITS-1:0]  held_tol;

    logic                 r_in_vld;
    logic signed [AB-1:0] r_scope_azim, r_scope_elev, r_goal_azim, r_goal_elev;

    logic                 r_out_vld;
    logic signed [AB-1:0] r_new_azim, r_new_elev;
    logic                 r_changed;
    t_limit_flags         r_flags;

    logic                 advance;
    logic signed [AB-1:0] clamp_azim, clamp_elev;
    logic                 clamped;
    t_limit_flags         flags;
    logic signed [AB-1:0] held_azim;
    logic                 slewing;

    alg_cfg_regs #(
        .ANGLE_BITS (ANGLE_BITS),
        .CFG_W      (CFG_W)
    ) u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_elev_upper (elev_upper),
        .o_elev_lower (elev_lower),
        .o_azim_cw    (azim_cw),
        .o_azim_ccw   (azim_ccw),
        .o_held_tol   (held_tol)
    );

    assign advance       = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_scope_azim <= s_axis_tdata[AB-1:0];
            r_scope_elev <= s_axis_tdata[2*AB-1:AB];
            r_goal_azim  <= s_axis_tdata[3*AB-1:2*AB];
            r_goal_elev  <= s_axis_tdata[4*AB-1:3*AB];
        end
    end

    alg_clamp #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_clamp (
        .i_elev_upper (elev_upper),
        .i_elev_lower (elev_lower),
        .i_azim_cw    (azim_cw),
        .i_azim_ccw   (azim_ccw),
        .i_scope_azim (r_scope_azim),
        .i_scope_elev (r_scope_elev),
        .i_goal_azim  (r_goal_azim),
        .i_goal_elev  (r_goal_elev),
        .o_goal_azim  (clamp_azim),
        .o_goal_elev  (clamp_elev),
        .o_clamped    (clamped),
        .o_flags      (flags)
    );

    alg_slewup #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_slewup (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (advance),
        .i_below_lower (flags.dn),
        .i_scope_azim  (r_scope_azim),
        .i_held_tol    (held_tol),
        .o_held_azim   (held_azim),
        .o_slewing     (slewing)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_new_azim <= flags.dn ? held_azim : clamp_azim;
            r_new_elev <= clamp_elev;
            r_changed  <= clamped || flags.dn;
            r_flags    <= flags;
        end
    end

    assign m_axis_tvalid = r_out_vld;

    always_comb begin
        m_axis_tdata                = '0;
        m_axis_tdata[AB-1:0]        = r_new_azim;
        m_axis_tdata[2*AB-1:AB]     = r_new_elev;
        m_axis_tdata[2*AB]          = r_changed;
        m_axis_tdata[2*AB+1]        = !(r_flags.up || r_flags.dn || r_flags.cw || r_flags.cc);
        m_axis_tdata[2*AB+2]        = r_flags.cc;
        m_axis_tdata[2*AB+3]        = r_flags.cw;
        m_axis_tdata[2*AB+4]        = r_flags.dn;
        m_axis_tdata[2*AB+5]        = r_flags.up;
    end

`include "axis_limit_guard_with_slewup_unit_assert.svh"

    `ALG_ASSERT_CLK(a_adv_fills_out, i_clk, i_rst_n, advance |=> m_axis_tvalid)
    `ALG_ASSERT_CLK(a_slew_after_low, i_clk, i_rst_n, (advance && flags.dn) |=> slewing)
    `ALG_ASSERT_CLK(a_low_marks_change, i_clk, i_rst_n, (r_out_vld && r_flags.dn) |-> r_changed)
    `ALG_ASSERT_ALWAYS(a_ready_when_empty, i_clk, !r_in_vld |-> s_axis_tready)

endmodule

`default_nettype wire

// ===== bench/guard_checker.sv =====
module guard_checker
    import alg_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_addr,
    input  logic [31:0]             i_cfg_wdata,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    // scope_azim, scope_elev, goal_azim, goal_elev
    input  logic [127:0]            i_in_data,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    // new_goal_azim, new_goal_elev, goal_changed, scope_inside,
    // over_counter_limit, over_clockwise_limit, under_lower_limit,
    // over_upper_limit, zero pad
    input  logic [71:0]             i_out_data,
    output int                      o_pending,
    output int                      o_mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] new_goal_azim;
        logic [31:0] new_goal_elev;
        logic        goal_changed;
        logic        scope_inside;
        logic        over_counter_limit;
        logic        over_clockwise_limit;
        logic        under_lower_limit;
        logic        over_upper_limit;
    } t_guard_result;

    logic signed [31:0] elev_upper;
    logic signed [31:0] elev_lower;
    logic signed [31:0] azim_cw;
    logic signed [31:0] azim_ccw;
    logic [30:0]        azim_tol;
    logic               slewing;
    logic signed [31:0] held_azim;

    t_guard_result guarded_goals[$];
    int            mismatch_cnt = 0;
    int            result_cnt = 0;

    assign o_mismatches = mismatch_cnt;

    task automatic report_mismatch(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 50) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    function automatic t_guard_result clamp_goal(input logic signed [31:0] s_az,
                                                 input logic signed [31:0] s_el,
                                                 input logic signed [31:0] g_az,
                                                 input logic signed [31:0] g_el);
        t_guard_result      r;
        logic signed [31:0] az;
        logic signed [31:0] el;
        logic               changed;
        longint             gap;
        r = '0;
        az = g_az;
        el = g_el;
        changed = 1'b0;
        r.over_upper_limit = s_el > elev_upper;
        r.under_lower_limit = s_el < elev_lower;
        r.over_clockwise_limit = s_az > azim_cw;
        r.over_counter_limit = s_az < azim_ccw;
        // lower limit and counterclockwise limit win when crossed
        if (el > elev_upper) begin
            el = elev_upper;
            changed = 1'b1;
        end
        if (el < elev_lower) begin
            el = elev_lower;
            changed = 1'b1;
        end
        if (az > azim_cw) begin
            az = azim_cw;
            changed = 1'b1;
        end
        if (az < azim_ccw) begin
            az = azim_ccw;
            changed = 1'b1;
        end
        if (r.under_lower_limit) begin
            gap = longint'(held_azim) - longint'(s_az);
            if (gap < 0) begin
                gap = -gap;
            end
            if (!slewing || gap > longint'(azim_tol)) begin
                slewing = 1'b1;
                held_azim = s_az;
            end
            az = held_azim;
            changed = 1'b1;
        end else begin
            slewing = 1'b0;
        end
        r.new_goal_azim = az;
        r.new_goal_elev = el;
        r.goal_changed = changed;
        r.scope_inside = !(r.over_upper_limit || r.under_lower_limit ||
                           r.over_clockwise_limit || r.over_counter_limit);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_guard_result got;
        t_guard_result want;
        if (!i_rst_n) begin
            elev_upper = ELEV_UPPER_RST[31:0];
            elev_lower = ELEV_LOWER_RST[31:0];
            azim_cw = AZIM_CW_RST[31:0];
            azim_ccw = AZIM_CCW_RST[31:0];
            azim_tol = HELD_TOL_RST;
            slewing = 1'b0;
            held_azim = '0;
            guarded_goals.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    REG_ELEV_UPPER: elev_upper = i_cfg_wdata;
                    REG_ELEV_LOWER: elev_lower = i_cfg_wdata;
                    REG_AZIM_CW:    azim_cw = i_cfg_wdata;
                    REG_AZIM_CCW:   azim_ccw = i_cfg_wdata;
                    REG_HELD_TOL:   azim_tol = i_cfg_wdata[30:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                guarded_goals.push_back(clamp_goal(i_in_data[31:0], i_in_data[63:32],
                                                   i_in_data[95:64], i_in_data[127:96]));
            end
            if (i_out_valid && i_out_ready) begin
                got.new_goal_azim = i_out_data[31:0];
                got.new_goal_elev = i_out_data[63:32];
                got.goal_changed = i_out_data[64];
                got.scope_inside = i_out_data[65];
                got.over_counter_limit = i_out_data[66];
                got.over_clockwise_limit = i_out_data[67];
                got.under_lower_limit = i_out_data[68];
                got.over_upper_limit = i_out_data[69];
                if (guarded_goals.size() == 0) begin
                    report_mismatch($sformatf("unexpected item %p", got));
                end else begin
                    want = guarded_goals.pop_front();
                    if (got !== want) begin
                        report_mismatch($sformatf("item %0d got %p want %p",
                                                  result_cnt, got, want));
                    end
                end
                result_cnt++;
            end
        end
        o_pending <= guarded_goals.size();
    end

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import alg_pkg::*;

    localparam logic [31:0] ANG_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] ANG_MIN = 32'h8000_0000;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_addr = REG_ELEV_UPPER;
    logic [31:0]             cfg_wdata = '0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [127:0]            s_data = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [71:0]             m_data;

    int          pending;
    int          mismatches;
    int          sender_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_reqs = 0;
    logic [31:0] lim [0:4];

    axis_limit_guard_with_slewup_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_addr    (cfg_addr),
        .i_cfg_wdata   (cfg_wdata),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data)
    );

    guard_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_addr   (cfg_addr),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (s_valid),
        .i_in_ready   (s_ready),
        .i_in_data    (s_data),
        .i_out_valid  (m_valid),
        .i_out_ready  (m_ready),
        .i_out_data   (m_data),
        .o_pending    (pending),
        .o_mismatches (mismatches)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // receiver, with one long hold-off
    initial begin : receiver
        int holds_done;
        holds_done = 0;
        forever begin
            if (hold_reqs != holds_done) begin
                holds_done++;
                m_ready <= 1'b0;
                repeat (80) @(posedge i_clk);
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
                @(posedge i_clk);
            end
        end
    end

    task automatic send_item(input logic [31:0] sa, input logic [31:0] se,
                             input logic [31:0] ga, input logic [31:0] ge);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data <= {ge, ga, se, sa};
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic put_reg(input t_cfg_idx idx, input logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        lim[idx] = val;
        @(posedge i_clk);
    endtask

    task automatic write_limits(input logic [31:0] up, input logic [31:0] lo,
                                input logic [31:0] cw, input logic [31:0] ccw,
                                input logic [31:0] tol);
        put_reg(REG_ELEV_UPPER, up);
        put_reg(REG_ELEV_LOWER, lo);
        put_reg(REG_AZIM_CW, cw);
        put_reg(REG_AZIM_CCW, ccw);
        put_reg(REG_HELD_TOL, tol);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [31:0] angle_near(input logic [31:0] lim_val);
        case ($urandom_range(7))
            0: return lim_val;
            1: return lim_val + 1;
            2: return lim_val - 1;
            3: return lim_val + $urandom_range(4000) - 2000;
            4: return ANG_MAX;
            5: return ANG_MIN;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] azim_pick();
        return angle_near($urandom_range(1) ? lim[REG_AZIM_CW] : lim[REG_AZIM_CCW]);
    endfunction

    function automatic logic [31:0] elev_pick();
        return angle_near($urandom_range(1) ? lim[REG_ELEV_UPPER] : lim[REG_ELEV_LOWER]);
    endfunction

    // mostly slew-up runs below the lower limit, the rest loose items
    task automatic random_burst(inout int count);
        logic [31:0] track;
        logic [31:0] tol;
        logic [31:0] delta;
        logic [31:0] azim;
        logic [31:0] elev;
        int          run;
        tol = lim[REG_HELD_TOL];
        if ($urandom_range(99) < 60) begin
            run = $urandom_range(3, 8);
            track = azim_pick();
            for (int k = 0; k < run; k++) begin
                case ($urandom_range(5))
                    0: delta = '0;
                    1: delta = tol;
                    2: delta = -tol;
                    3: delta = tol + 1;
                    4: delta = -(tol + 1);
                    default: delta = $urandom_range(2000) - 1000;
                endcase
                azim = track + delta;
                if (delta == tol + 1 || delta == -(tol + 1)) begin
                    track = azim;
                end
                if (k == run - 1 && $urandom_range(1)) begin
                    elev = elev_pick();
                end else begin
                    elev = lim[REG_ELEV_LOWER] - $urandom_range(1, 3000);
                end
                send_item(azim, elev, azim_pick(), elev_pick());
                count++;
            end
        end else begin
            send_item(azim_pick(), elev_pick(), azim_pick(), elev_pick());
            count++;
        end
    endtask

    initial begin : stimulus
        logic [31:0] up, lo, cw, ccw, tol, a, b;
        int          count;
        bit          hold_issued;
        bit          pause_issued;
        hold_issued = 0;
        pause_issued = 0;
        lim[REG_ELEV_UPPER] = ELEV_UPPER_RST[31:0];
        lim[REG_ELEV_LOWER] = ELEV_LOWER_RST[31:0];
        lim[REG_AZIM_CW] = AZIM_CW_RST[31:0];
        lim[REG_AZIM_CCW] = AZIM_CCW_RST[31:0];
        lim[REG_HELD_TOL] = {1'b0, HELD_TOL_RST};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        up = lim[REG_ELEV_UPPER];
        lo = lim[REG_ELEV_LOWER];
        cw = lim[REG_AZIM_CW];
        ccw = lim[REG_AZIM_CCW];
        tol = lim[REG_HELD_TOL];
        send_item(32'd0, 32'd1000, 32'd1000, 32'd2000);
        send_item(ANG_MAX, ANG_MAX, ANG_MAX, ANG_MAX);
        send_item(cw, up, ccw, lo);
        send_item(cw + 1, up + 1, ccw - 1, lo - 1);
        send_item(ccw - 1, 32'd5000, cw + 1, up + 1);
        // slew-up starts, held azimuth kept at exactly the tolerance, then replaced
        send_item(32'd1000, lo - 1, 32'd200000, 32'd50000);
        send_item(32'd1000 + tol, lo - 5000, 32'd0, 32'd0);
        send_item(32'd1000 - tol - 1, lo - 1, cw + 7, up + 7);
        send_item(ANG_MIN, ANG_MIN, ANG_MIN, ANG_MIN);
        send_item(ANG_MAX, lo - 1, ANG_MIN, ANG_MAX);
        // leave slew-up, then come back close to the stale held azimuth
        send_item(32'd0, lo, 32'd0, 32'd0);
        send_item(ANG_MAX - 5, lo - 10, 32'd0, 32'd0);
        send_item(ANG_MAX - 2, lo - 10, 32'd100, 32'd100);
        send_item(32'h5555_5555, 32'h5555_5555, 32'h5555_5555, 32'h5555_5555);
        send_item(32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'hAAAA_AAAA);
        send_item(32'd0, 32'd0, 32'd0, 32'd0);
        wait_drained();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_limits(ANG_MAX, ANG_MIN, ANG_MAX, ANG_MIN, 32'h7FFF_FFFF);
                1: write_limits(-32'sd1000000, 32'sd1000000, -32'sd2000000, 32'sd2000000, '0);
                2: write_limits(ANG_MIN, ANG_MAX, ANG_MIN, ANG_MAX, 32'h7FFF_FFFF);
                3: begin
                    a = $urandom;
                    b = $urandom;
                    if ($signed(a) > $signed(b)) begin
                        write_limits(a, b, $urandom_range(ANG_MAX), -$urandom_range(ANG_MAX),
                                     $urandom_range(5_000_000));
                    end else begin
                        write_limits(b, a, $urandom_range(ANG_MAX), -$urandom_range(ANG_MAX),
                                     $urandom_range(5_000_000));
                    end
                end
                4: write_limits(ELEV_UPPER_RST[31:0], ELEV_LOWER_RST[31:0],
                                AZIM_CW_RST[31:0], AZIM_CCW_RST[31:0], '0);
                default: write_limits($urandom, $urandom, $urandom, $urandom, $urandom >> 1);
            endcase
            case (ph % 4)
                0: begin
                    sender_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    sender_idle_pct = 65;
                    recv_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    recv_stall_pct = 65;
                end
                default: begin
                    sender_idle_pct = 6;
                    recv_stall_pct = 6;
                end
            endcase
            count = 0;
            while (count < 90) begin
                random_burst(count);
                if (ph == 4 && !hold_issued && count >= 30) begin
                    hold_issued = 1;
                    hold_reqs++;
                end
                if (ph == 5 && !pause_issued && count >= 40) begin
                    pause_issued = 1;
                    wait_drained();
                end
            end
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
